[src/bdr_pkg.sv]
// Package for the bounded deque: opcodes, status codes, controller states and the
// command and status structs that join the controller to the datapath.
// Depends on nothing; bdr_if, bdr_ctrl, bdr_dpath and bounded_deque_ring use it.
package bdr_pkg;

	localparam int unsigned OP_W     = 3;
	localparam int unsigned WORD_W   = 32;
	localparam int unsigned STATUS_W = 2;

	typedef enum logic [OP_W-1:0] {
		OP_PUSH_BACK  = 3'd0,
		OP_PUSH_FRONT = 3'd1,
		OP_POP_FRONT  = 3'd2,
		OP_POP_BACK   = 3'd3,
		OP_LIST       = 3'd4
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_OK    = 2'd0,
		STAT_EMPTY = 2'd1,
		STAT_FULL  = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_DATA
	} state_t;

	typedef enum logic [2:0] {
		ACT_NONE,
		ACT_PUSH_BACK,
		ACT_PUSH_FRONT,
		ACT_POP_FRONT,
		ACT_POP_BACK,
		ACT_LIST_FIRST,
		ACT_LIST_NEXT
	} act_t;

	typedef enum logic [1:0] {
		OUT_NONE,
		OUT_CODE,
		OUT_DATA
	} outsel_t;

	typedef struct packed {
		logic    latch;
		act_t    act;
		outsel_t out_sel;
		status_t code;
	} cmd_t;

	typedef struct packed {
		op_t  op;
		logic empty;
		logic full;
		logic more;
	} sts_t;

endpackage

[src/bdr_if.sv]
// Valid/ready channel interfaces for the deque's request and response streams.
// Depends on bdr_pkg for the field widths.
interface bdr_req_if;
	logic                                valid;
	logic                                ready;
	logic [bdr_pkg::OP_W-1:0]            opcode;
	logic signed [bdr_pkg::WORD_W-1:0]   value;

	modport source (output valid, output opcode, output value, input ready);
	modport sink (input valid, input opcode, input value, output ready);
endinterface

interface bdr_rsp_if;
	logic                                valid;
	logic                                ready;
	logic signed [bdr_pkg::WORD_W-1:0]   word;
	logic [bdr_pkg::STATUS_W-1:0]        status;
	logic                                last;

	modport source (output valid, output word, output status, output last, input ready);
	modport sink (input valid, input word, input status, input last, output ready);
endinterface

[src/bdr_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module bdr_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

[src/bdr_ctrl.sv]
// Controller state machine of the deque: handshakes, sequencing of operations and the
// valid flag of the result register. Depends on bdr_pkg.
module bdr_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	input  bdr_pkg::sts_t sts,
	output bdr_pkg::cmd_t cmd
);

	bdr_pkg::state_t state_q;
	bdr_pkg::state_t state_d;
	logic            out_valid_q;
	logic            out_free;
	logic            load;

	assign out_free  = !out_valid_q || rsp_ready;
	assign load      = (cmd.out_sel != bdr_pkg::OUT_NONE);
	assign req_ready = (state_q == bdr_pkg::ST_IDLE);
	assign rsp_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			bdr_pkg::ST_IDLE: begin
				if (req_valid) begin
					state_d = bdr_pkg::ST_EXEC;
				end
			end
			bdr_pkg::ST_EXEC: begin
				if (out_free) begin
					unique case (sts.op)
						bdr_pkg::OP_POP_FRONT, bdr_pkg::OP_POP_BACK, bdr_pkg::OP_LIST: begin
							state_d = sts.empty ? bdr_pkg::ST_IDLE : bdr_pkg::ST_DATA;
						end
						default: begin
							state_d = bdr_pkg::ST_IDLE;
						end
					endcase
				end
			end
			bdr_pkg::ST_DATA: begin
				if (out_free && !sts.more) begin
					state_d = bdr_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = bdr_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd.latch   = 1'b0;
		cmd.act     = bdr_pkg::ACT_NONE;
		cmd.out_sel = bdr_pkg::OUT_NONE;
		cmd.code    = bdr_pkg::STAT_OK;
		unique case (state_q)
			bdr_pkg::ST_IDLE: begin
				cmd.latch = req_valid;
			end
			bdr_pkg::ST_EXEC: begin
				if (out_free) begin
					unique case (sts.op)
						bdr_pkg::OP_PUSH_BACK, bdr_pkg::OP_PUSH_FRONT: begin
							cmd.out_sel = bdr_pkg::OUT_CODE;
							if (sts.full) begin
								cmd.code = bdr_pkg::STAT_FULL;
							end else begin
								cmd.act = (sts.op == bdr_pkg::OP_PUSH_BACK) ?
									bdr_pkg::ACT_PUSH_BACK : bdr_pkg::ACT_PUSH_FRONT;
							end
						end
						bdr_pkg::OP_POP_FRONT, bdr_pkg::OP_POP_BACK, bdr_pkg::OP_LIST: begin
							if (sts.empty) begin
								cmd.out_sel = bdr_pkg::OUT_CODE;
								cmd.code    = bdr_pkg::STAT_EMPTY;
							end else if (sts.op == bdr_pkg::OP_POP_FRONT) begin
								cmd.act = bdr_pkg::ACT_POP_FRONT;
							end else if (sts.op == bdr_pkg::OP_POP_BACK) begin
								cmd.act = bdr_pkg::ACT_POP_BACK;
							end else begin
								cmd.act = bdr_pkg::ACT_LIST_FIRST;
							end
						end
						default: begin
							cmd.act = bdr_pkg::ACT_NONE;
						end
					endcase
				end
			end
			bdr_pkg::ST_DATA: begin
				if (out_free) begin
					cmd.out_sel = bdr_pkg::OUT_DATA;
					if (sts.more) begin
						cmd.act = bdr_pkg::ACT_LIST_NEXT;
					end
				end
			end
			default: begin
				cmd.latch = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= bdr_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// A result is never written over one that has not yet been transferred.
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> out_free)
		else $error("result register loaded while occupied");

	// Store accesses are only commanded once a transfer has been accepted.
	a_act_after_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.act != bdr_pkg::ACT_NONE) |-> (state_q != bdr_pkg::ST_IDLE))
		else $error("store access commanded while idle");

endmodule

[src/bdr_dpath.sv]
// Datapath of the deque: front index, entry count, list walker, ring store and the
// result register. Depends on bdr_pkg and bdr_ram.
module bdr_dpath #(
	parameter int unsigned CAPACITY = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  bdr_pkg::cmd_t                     cmd,
	output bdr_pkg::sts_t                     sts,
	input  logic [bdr_pkg::OP_W-1:0]          req_opcode,
	input  logic signed [bdr_pkg::WORD_W-1:0] req_value,
	output logic signed [bdr_pkg::WORD_W-1:0] rsp_word,
	output logic [bdr_pkg::STATUS_W-1:0]      rsp_status,
	output logic                              rsp_last
);

	localparam int unsigned AW = $clog2(CAPACITY);
	localparam int unsigned CW = $clog2(CAPACITY + 1);
	localparam int unsigned SW = AW + 1;
	localparam logic [SW-1:0] CAP_S    = SW'(CAPACITY);
	localparam logic [CW-1:0] CAP_C    = CW'(CAPACITY);
	localparam logic [AW-1:0] LAST_IDX = AW'(CAPACITY - 1);

	logic [bdr_pkg::OP_W-1:0]          op_q;
	logic signed [bdr_pkg::WORD_W-1:0] value_q;
	logic [AW-1:0]                     front_q;
	logic [CW-1:0]                     count_q;
	logic [AW-1:0]                     ptr_q;
	logic [CW-1:0]                     idx_q;
	logic                              rd_last_q;
	logic signed [bdr_pkg::WORD_W-1:0] word_q;
	logic [bdr_pkg::STATUS_W-1:0]      status_q;
	logic                              last_q;

	logic                              wr_en;
	logic [AW-1:0]                     wr_addr;
	logic                              rd_en;
	logic [AW-1:0]                     rd_addr;
	logic [bdr_pkg::WORD_W-1:0]        rd_data;
	logic [SW-1:0]                     back_sum;
	logic [AW-1:0]                     back_slot;
	logic [AW-1:0]                     tail_slot;
	logic [AW-1:0]                     front_dec;
	logic [AW-1:0]                     front_inc;
	logic [AW-1:0]                     ptr_inc;

	function automatic logic [AW-1:0] wrap_idx(input logic [SW-1:0] x);
		wrap_idx = (x >= CAP_S) ? AW'(x - CAP_S) : AW'(x);
	endfunction

	function automatic logic [AW-1:0] inc_idx(input logic [AW-1:0] p);
		inc_idx = (p == LAST_IDX) ? '0 : p + 1'b1;
	endfunction

	function automatic logic [AW-1:0] dec_idx(input logic [AW-1:0] p);
		dec_idx = (p == '0) ? LAST_IDX : p - 1'b1;
	endfunction

	assign back_sum  = {1'b0, front_q} + SW'(count_q);
	assign back_slot = wrap_idx(back_sum);
	assign tail_slot = wrap_idx(back_sum - 1'b1);
	assign front_dec = dec_idx(front_q);
	assign front_inc = inc_idx(front_q);
	assign ptr_inc   = inc_idx(ptr_q);

	assign sts.op    = bdr_pkg::op_t'(op_q);
	assign sts.empty = (count_q == '0);
	assign sts.full  = (count_q == CAP_C);
	assign sts.more  = !rd_last_q;

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = back_slot;
		rd_en   = 1'b0;
		rd_addr = front_q;
		unique case (cmd.act)
			bdr_pkg::ACT_PUSH_BACK: begin
				wr_en = 1'b1;
			end
			bdr_pkg::ACT_PUSH_FRONT: begin
				wr_en   = 1'b1;
				wr_addr = front_dec;
			end
			bdr_pkg::ACT_POP_FRONT, bdr_pkg::ACT_LIST_FIRST: begin
				rd_en = 1'b1;
			end
			bdr_pkg::ACT_POP_BACK: begin
				rd_en   = 1'b1;
				rd_addr = tail_slot;
			end
			bdr_pkg::ACT_LIST_NEXT: begin
				rd_en   = 1'b1;
				rd_addr = ptr_q;
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	bdr_ram #(
		.WIDTH (bdr_pkg::WORD_W),
		.DEPTH (CAPACITY)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (value_q),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q   <= '0;
			count_q   <= '0;
			ptr_q     <= '0;
			idx_q     <= '0;
			rd_last_q <= 1'b1;
		end else begin
			unique case (cmd.act)
				bdr_pkg::ACT_PUSH_BACK: begin
					count_q <= count_q + 1'b1;
				end
				bdr_pkg::ACT_PUSH_FRONT: begin
					front_q <= front_dec;
					count_q <= count_q + 1'b1;
				end
				bdr_pkg::ACT_POP_FRONT: begin
					front_q   <= front_inc;
					count_q   <= count_q - 1'b1;
					rd_last_q <= 1'b1;
				end
				bdr_pkg::ACT_POP_BACK: begin
					count_q   <= count_q - 1'b1;
					rd_last_q <= 1'b1;
				end
				bdr_pkg::ACT_LIST_FIRST: begin
					ptr_q     <= front_inc;
					idx_q     <= CW'(1);
					rd_last_q <= (count_q == CW'(1));
				end
				bdr_pkg::ACT_LIST_NEXT: begin
					ptr_q     <= ptr_inc;
					idx_q     <= idx_q + 1'b1;
					rd_last_q <= ((idx_q + 1'b1) == count_q);
				end
				default: begin
					rd_last_q <= rd_last_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			op_q    <= req_opcode;
			value_q <= req_value;
		end
		unique case (cmd.out_sel)
			bdr_pkg::OUT_CODE: begin
				word_q   <= '0;
				status_q <= cmd.code;
				last_q   <= 1'b1;
			end
			bdr_pkg::OUT_DATA: begin
				word_q   <= rd_data;
				status_q <= bdr_pkg::STAT_OK;
				last_q   <= rd_last_q;
			end
			default: begin
				word_q <= word_q;
			end
		endcase
	end

	assign rsp_word   = word_q;
	assign rsp_status = status_q;
	assign rsp_last   = last_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CAP_C)
		else $error("entry count exceeds capacity");

	a_front_bound: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, front_q} < CAP_S)
		else $error("front index out of range");

	// A push is never carried out on a full queue, nor a removal on an empty one.
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.act == bdr_pkg::ACT_PUSH_BACK || cmd.act == bdr_pkg::ACT_PUSH_FRONT)
		|-> (count_q < CAP_C))
		else $error("push executed on a full queue");

	a_pop_data: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.act == bdr_pkg::ACT_POP_FRONT || cmd.act == bdr_pkg::ACT_POP_BACK)
		|=> (count_q == $past(count_q) - 1'b1))
		else $error("pop did not remove exactly one entry");

endmodule

[src/bounded_deque_ring.sv]
// Bounded double-ended queue of signed 32-bit words held in a ring store of CAPACITY
// entries. Each request transfer carries an opcode (push back, push front, pop front,
// pop back or list) and one request is worked on at a time. A push, or a pop or list
// that finds the queue empty, gives a single status result; a pop gives its word, which
// comes through the store's registered read port; a list of N words gives one word per
// cycle while the response side is ready, the last one marked. Opcodes 5 to 7 are
// dropped with no result. A result that has not yet been transferred holds the
// controller. The next request is taken in the cycle after the final result of the
// previous one is loaded. The store needs no clearing after reset.
// Depends on bdr_pkg, bdr_if, bdr_ram, bdr_ctrl and bdr_dpath.
module bounded_deque_ring #(
	parameter int unsigned CAPACITY = 32
) (
	input logic       clk,
	input logic       arst_n,
	bdr_req_if.sink   req,
	bdr_rsp_if.source rsp
);

	bdr_pkg::cmd_t cmd;
	bdr_pkg::sts_t sts;

	bdr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	bdr_dpath #(
		.CAPACITY (CAPACITY)
	) u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.req_opcode (req.opcode),
		.req_value  (req.value),
		.rsp_word   (rsp.word),
		.rsp_status (rsp.status),
		.rsp_last   (rsp.last)
	);

endmodule
